// ===== hw/rtl/latency_stats_histogram_assert.svh =====
// Assertion macros for the latency statistics histogram block.
// Included by the top level; no other dependencies.
`ifndef LATENCY_STATS_HISTOGRAM_ASSERT_SVH
`define LATENCY_STATS_HISTOGRAM_ASSERT_SVH

`ifndef SYNTH
`define LSH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");
`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");
`else
`define LSH_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/lsh_pkg.sv =====
// Shared types and constants for the latency statistics histogram.
// No dependencies; used by lsh_arith_unit and latency_stats_histogram.
`timescale 1ns / 1ps
`default_nettype none

package lsh_pkg;

   localparam int MAX_BUCKETS = 64;
   localparam int SAMPLE_BITS = 20;
   localparam int COUNT_BITS  = 24;
   localparam int SUM_BITS    = 44;
   localparam int SQ_BITS     = 64;
   localparam int VAR_BITS    = 40;
   localparam int IDX_BITS    = 6;
   localparam int ACT_BITS    = 2;
   localparam int WIDTH_BITS  = 16;
   localparam int BUCKETS_BITS = 7;
   localparam int STEP_BITS   = 7;
   localparam int REM_BITS    = COUNT_BITS + 2;

   localparam logic [WIDTH_BITS-1:0]   BUCKET_WIDTH_RESET = 16'd1000;
   localparam logic [BUCKETS_BITS-1:0] BUCKETS_RESET      = 7'd64;

   localparam logic [ACT_BITS-1:0] ACT_RECORD = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_READ   = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 2'd2;

   localparam logic REG_BUCKET_WIDTH   = 1'b0;
   localparam logic REG_BUCKETS_IN_USE = 1'b1;

   typedef struct packed {
      logic                       go;
      logic                       root;
      logic [SQ_BITS-1:0]         num;
      logic [COUNT_BITS-1:0]      den;
      logic [STEP_BITS-1:0]       steps;
   } unit_cmd_type;

   typedef struct packed {
      logic                       done;
      logic [VAR_BITS-1:0]        quo;
   } unit_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsh_arith_unit.sv =====
// Shared restoring divide and square-root unit, one result bit per cycle.
// Depends on lsh_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lsh_arith_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lsh_pkg::unit_cmd_type cmd,
   output lsh_pkg::unit_sts_type     sts
);

   localparam int RW = lsh_pkg::REM_BITS;

   logic [lsh_pkg::SQ_BITS-1:0]    num_ff;
   logic [RW-1:0]                  rem_ff;
   logic [lsh_pkg::VAR_BITS-1:0]   quo_ff;
   logic [lsh_pkg::COUNT_BITS-1:0] den_ff;
   logic [lsh_pkg::STEP_BITS-1:0]  cnt_ff;
   logic                           root_ff;
   logic                           run_ff;
   logic                           done_ff;

   logic [RW-1:0] rem_sh_in;
   logic [RW-1:0] trial_in;
   logic          fits_in;

   always_comb begin
      if (root_ff) begin
         rem_sh_in = {rem_ff[RW-3:0], num_ff[lsh_pkg::SQ_BITS-1 -: 2]};
         trial_in  = {quo_ff[RW-3:0], 2'b01};
      end else begin
         rem_sh_in = {rem_ff[RW-2:0], num_ff[lsh_pkg::SQ_BITS-1]};
         trial_in  = {2'b00, den_ff};
      end
      fits_in = rem_sh_in >= trial_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            num_ff  <= cmd.num;
            rem_ff  <= '0;
            quo_ff  <= '0;
            den_ff  <= cmd.den;
            root_ff <= cmd.root;
            cnt_ff  <= cmd.steps;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= fits_in ? rem_sh_in - trial_in : rem_sh_in;
            quo_ff <= {quo_ff[lsh_pkg::VAR_BITS-2:0], fits_in};
            num_ff <= root_ff ? {num_ff[lsh_pkg::SQ_BITS-3:0], 2'b00}
                              : {num_ff[lsh_pkg::SQ_BITS-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == lsh_pkg::STEP_BITS'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/latency_stats_histogram.sv =====
// Top level of the latency statistics histogram: sequencer, statistics,
// bucket memory and APB-style register port. Uses lsh_pkg and lsh_arith_unit.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high while busy is low. Its action is
// record a sample, read a bucket or clear everything. busy then stays high
// until the result is shown: rsp_valid is high for exactly one cycle with
// all statistics and one bucket count on the rsp_ ports. The receiver
// cannot stall; the result is simply presented once.
// A record runs the shared divide and root unit, which produces one result
// bit per cycle: the bucket divide (20 steps), the mean divide (44), the
// square-sum divide (64) and the square root (20); a read runs all but the
// bucket divide. A clear, or a read while no sample is counted, runs none.
// A new item may be started in the cycle the result strobe is high. The
// registers bucket_width (address 0) and buckets_in_use (address 4) are
// written through the APB-style port; the user must write them only while
// the block is idle, which the block itself does not enforce. Reset restores
// both registers and zeroes all statistics and every bucket counter at once.

`include "latency_stats_histogram_assert.svh"

module latency_stats_histogram #(
   parameter int MAX_BUCKETS = lsh_pkg::MAX_BUCKETS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire logic [lsh_pkg::ACT_BITS-1:0]     req_action,
   input  wire logic [lsh_pkg::SAMPLE_BITS-1:0]  req_sample_ns,
   input  wire logic [lsh_pkg::IDX_BITS-1:0]     req_bucket_index,
   output      logic                             rsp_valid,
   output      logic [lsh_pkg::COUNT_BITS-1:0]   rsp_sample_count,
   output      logic [lsh_pkg::SAMPLE_BITS-1:0]  rsp_min_ns,
   output      logic [lsh_pkg::SAMPLE_BITS-1:0]  rsp_max_ns,
   output      logic [lsh_pkg::SUM_BITS-1:0]     rsp_sum_ns,
   output      logic [lsh_pkg::SAMPLE_BITS-1:0]  rsp_mean_ns,
   output      logic [lsh_pkg::VAR_BITS-1:0]     rsp_variance_ns2,
   output      logic [lsh_pkg::SAMPLE_BITS-1:0]  rsp_stddev_ns,
   output      logic [lsh_pkg::COUNT_BITS-1:0]   rsp_bucket_value,
   output      logic [lsh_pkg::IDX_BITS-1:0]     rsp_bucket_used,
   output      logic                             rsp_stats_full,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [2:0]                       paddr,
   input  wire logic [31:0]                      pwdata,
   output      logic [31:0]                      prdata,
   output      logic                             pready
);

   localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW = $clog2(MAX_BUCKETS + 1);
   localparam int SB = lsh_pkg::SAMPLE_BITS;
   localparam int CB = lsh_pkg::COUNT_BITS;
   localparam int PB = 2 * lsh_pkg::SAMPLE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_BDIV,
      ST_BREAD,
      ST_BWRITE,
      ST_RREAD,
      ST_RDATA,
      ST_MEAN_GO,
      ST_MEAN,
      ST_MSQ,
      ST_MSQ_MUL,
      ST_VAR,
      ST_ROOT
   } state_type;

   state_type state_ff;

   logic [lsh_pkg::WIDTH_BITS-1:0]   width_ff;
   logic [lsh_pkg::BUCKETS_BITS-1:0] biu_ff;

   logic [CB-1:0]                count_ff;
   logic [lsh_pkg::SUM_BITS-1:0] sum_ff;
   logic [lsh_pkg::SQ_BITS-1:0]  sumsq_ff;
   logic [SB-1:0]                min_ff;
   logic [SB-1:0]                max_ff;
   logic [MAX_BUCKETS-1:0]       vld_ff;

   logic [SB-1:0]                smp_ff;
   logic [IW-1:0]                bidx_ff;
   logic                         range_ok_ff;
   logic [CB-1:0]                bval_ff;
   logic [lsh_pkg::IDX_BITS-1:0] used_ff;
   logic [SB-1:0]                mean_ff;
   logic [lsh_pkg::VAR_BITS-1:0] msq_ff;
   logic [PB-1:0]                prod_ff;

   logic                         rsp_valid_ff;
   logic [CB-1:0]                rsp_count_ff;
   logic [SB-1:0]                rsp_min_ff;
   logic [SB-1:0]                rsp_max_ff;
   logic [lsh_pkg::SUM_BITS-1:0] rsp_sum_ff;
   logic [SB-1:0]                rsp_mean_ff;
   logic [lsh_pkg::VAR_BITS-1:0] rsp_var_ff;
   logic [SB-1:0]                rsp_stddev_ff;
   logic [CB-1:0]                rsp_bval_ff;
   logic [lsh_pkg::IDX_BITS-1:0] rsp_used_ff;
   logic                         rsp_full_ff;

   lsh_pkg::unit_cmd_type cmd_ff;
   lsh_pkg::unit_sts_type u_sts;

   logic [CB-1:0] mem [MAX_BUCKETS];
   logic [CB-1:0] rd_data_ff;
   logic          rd_en;
   logic          wr_en;
   logic [CB-1:0] wr_data;

   logic [SB-1:0]                mul_a;
   logic [PB-1:0]                mul_out;
   logic                         full_c;
   logic [lsh_pkg::SUM_BITS:0]   sum_add;
   logic [lsh_pkg::SQ_BITS:0]    sq_add;
   logic [NW-1:0]                n_eff;
   logic [SB-1:0]                q_bkt;
   logic [NW-1:0]                bkt;
   logic [CB-1:0]                old_cnt;
   logic [lsh_pkg::VAR_BITS-1:0] var_c;
   logic [lsh_pkg::WIDTH_BITS-1:0] width_eff;
   logic                         csr_wr;

   lsh_arith_unit u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .sts   (u_sts)
   );

   always_comb begin
      mul_a     = (state_ff == ST_SQUARE) ? smp_ff : mean_ff;
      mul_out   = PB'(mul_a) * PB'(mul_a);
      full_c    = &count_ff;
      sum_add   = {1'b0, sum_ff} + (lsh_pkg::SUM_BITS + 1)'(smp_ff);
      sq_add    = {1'b0, sumsq_ff} + (lsh_pkg::SQ_BITS + 1)'(prod_ff);
      width_eff = (width_ff == '0) ? lsh_pkg::WIDTH_BITS'(1) : width_ff;
      if (biu_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(biu_ff) > 32'(MAX_BUCKETS)) begin
         n_eff = NW'(MAX_BUCKETS);
      end else begin
         n_eff = NW'(biu_ff);
      end
      q_bkt   = u_sts.quo[SB-1:0];
      bkt     = (32'(q_bkt) >= 32'(n_eff)) ? n_eff - NW'(1) : NW'(q_bkt);
      old_cnt = vld_ff[bidx_ff] ? rd_data_ff : '0;
      wr_data = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
      var_c   = (msq_ff > prod_ff) ? msq_ff - prod_ff : '0;
      rd_en   = (state_ff == ST_BREAD) || ((state_ff == ST_RREAD) && range_ok_ff);
      wr_en   = (state_ff == ST_BWRITE);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[bidx_ff];
      end
      if (wr_en) begin
         mem[bidx_ff] <= wr_data;
      end
   end

   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      unique case (paddr[2])
         lsh_pkg::REG_BUCKET_WIDTH:   prdata = 32'(width_ff);
         lsh_pkg::REG_BUCKETS_IN_USE: prdata = 32'(biu_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lsh_pkg::BUCKET_WIDTH_RESET;
         biu_ff   <= lsh_pkg::BUCKETS_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            lsh_pkg::REG_BUCKET_WIDTH:   width_ff <= pwdata[lsh_pkg::WIDTH_BITS-1:0];
            lsh_pkg::REG_BUCKETS_IN_USE: biu_ff <= pwdata[lsh_pkg::BUCKETS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         vld_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         cmd_ff.go    <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  smp_ff      <= req_sample_ns;
                  bidx_ff     <= IW'(req_bucket_index);
                  range_ok_ff <= 32'(req_bucket_index) < 32'(MAX_BUCKETS);
                  used_ff     <= req_bucket_index;
                  priority case (req_action)
                     lsh_pkg::ACT_RECORD: begin
                        cmd_ff.go    <= 1'b1;
                        cmd_ff.root  <= 1'b0;
                        cmd_ff.num   <= {req_sample_ns, (lsh_pkg::SQ_BITS - SB)'(0)};
                        cmd_ff.den   <= CB'(width_eff);
                        cmd_ff.steps <= lsh_pkg::STEP_BITS'(SB);
                        state_ff     <= ST_SQUARE;
                     end
                     lsh_pkg::ACT_CLEAR: begin
                        count_ff <= '0;
                        sum_ff   <= '0;
                        sumsq_ff <= '0;
                        min_ff   <= '0;
                        max_ff   <= '0;
                        vld_ff   <= '0;
                        bval_ff  <= '0;
                        state_ff <= ST_MEAN_GO;
                     end
                     default: begin
                        state_ff <= ST_RREAD;
                     end
                  endcase
               end
            end
            ST_SQUARE: begin
               prod_ff  <= mul_out;
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (!full_c) begin
                  count_ff <= count_ff + 1'b1;
                  sum_ff   <= sum_add[lsh_pkg::SUM_BITS] ? '1
                                                         : sum_add[lsh_pkg::SUM_BITS-1:0];
                  sumsq_ff <= sq_add[lsh_pkg::SQ_BITS] ? '1 : sq_add[lsh_pkg::SQ_BITS-1:0];
                  if ((count_ff == '0) || (smp_ff < min_ff)) begin
                     min_ff <= smp_ff;
                  end
                  if (smp_ff > max_ff) begin
                     max_ff <= smp_ff;
                  end
               end
               state_ff <= ST_BDIV;
            end
            ST_BDIV: begin
               if (u_sts.done) begin
                  bidx_ff  <= IW'(bkt);
                  used_ff  <= lsh_pkg::IDX_BITS'(bkt);
                  state_ff <= ST_BREAD;
               end
            end
            ST_BREAD: begin
               state_ff <= ST_BWRITE;
            end
            ST_BWRITE: begin
               vld_ff[bidx_ff] <= 1'b1;
               bval_ff         <= wr_data;
               state_ff        <= ST_MEAN_GO;
            end
            ST_RREAD: begin
               state_ff <= ST_RDATA;
            end
            ST_RDATA: begin
               bval_ff  <= (range_ok_ff && vld_ff[bidx_ff]) ? rd_data_ff : '0;
               state_ff <= ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
               if (count_ff == '0) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_count_ff  <= count_ff;
                  rsp_min_ff    <= min_ff;
                  rsp_max_ff    <= max_ff;
                  rsp_sum_ff    <= sum_ff;
                  rsp_mean_ff   <= '0;
                  rsp_var_ff    <= '0;
                  rsp_stddev_ff <= '0;
                  rsp_bval_ff   <= bval_ff;
                  rsp_used_ff   <= used_ff;
                  rsp_full_ff   <= full_c;
                  state_ff      <= ST_IDLE;
               end else begin
                  cmd_ff.go    <= 1'b1;
                  cmd_ff.root  <= 1'b0;
                  cmd_ff.num   <= {sum_ff, (lsh_pkg::SQ_BITS - lsh_pkg::SUM_BITS)'(0)};
                  cmd_ff.den   <= count_ff;
                  cmd_ff.steps <= lsh_pkg::STEP_BITS'(lsh_pkg::SUM_BITS);
                  state_ff     <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               if (u_sts.done) begin
                  mean_ff      <= u_sts.quo[SB-1:0];
                  cmd_ff.go    <= 1'b1;
                  cmd_ff.root  <= 1'b0;
                  cmd_ff.num   <= sumsq_ff;
                  cmd_ff.den   <= count_ff;
                  cmd_ff.steps <= lsh_pkg::STEP_BITS'(lsh_pkg::SQ_BITS);
                  state_ff     <= ST_MSQ;
               end
            end
            ST_MSQ: begin
               if (u_sts.done) begin
                  msq_ff   <= u_sts.quo;
                  state_ff <= ST_MSQ_MUL;
               end
            end
            ST_MSQ_MUL: begin
               prod_ff  <= mul_out;
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               msq_ff       <= var_c;
               cmd_ff.go    <= 1'b1;
               cmd_ff.root  <= 1'b1;
               cmd_ff.num   <= {var_c, (lsh_pkg::SQ_BITS - lsh_pkg::VAR_BITS)'(0)};
               cmd_ff.den   <= '0;
               cmd_ff.steps <= lsh_pkg::STEP_BITS'(lsh_pkg::VAR_BITS / 2);
               state_ff     <= ST_ROOT;
            end
            ST_ROOT: begin
               if (u_sts.done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_count_ff  <= count_ff;
                  rsp_min_ff    <= min_ff;
                  rsp_max_ff    <= max_ff;
                  rsp_sum_ff    <= sum_ff;
                  rsp_mean_ff   <= mean_ff;
                  rsp_var_ff    <= msq_ff;
                  rsp_stddev_ff <= u_sts.quo[SB-1:0];
                  rsp_bval_ff   <= bval_ff;
                  rsp_used_ff   <= used_ff;
                  rsp_full_ff   <= full_c;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_min_ns       = rsp_min_ff;
   assign rsp_max_ns       = rsp_max_ff;
   assign rsp_sum_ns       = rsp_sum_ff;
   assign rsp_mean_ns      = rsp_mean_ff;
   assign rsp_variance_ns2 = rsp_var_ff;
   assign rsp_stddev_ns    = rsp_stddev_ff;
   assign rsp_bucket_value = rsp_bval_ff;
   assign rsp_bucket_used  = rsp_used_ff;
   assign rsp_stats_full   = rsp_full_ff;

   `LSH_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `LSH_ASSERT_SAME(a_result_when_idle, clock, reset, rsp_valid, !busy)
   `LSH_ASSERT_NEXT(a_result_one_beat, clock, reset, rsp_valid, !rsp_valid)
   `LSH_ASSERT_SAME(a_unit_done_awaited, clock, reset, u_sts.done,
                    state_ff == ST_BDIV || state_ff == ST_MEAN ||
                    state_ff == ST_MSQ || state_ff == ST_ROOT)

endmodule

`default_nettype wire
